// File: src/cots_pkg.sv
// shared types, constants and helpers for the class-order task scheduler
`default_nettype none

package cots_pkg;

    // sizes
    localparam int NUM_SLOTS     = 8;
    localparam int ORDER_LEN     = 9;
    localparam int CLASS_ENTRIES = 9;
    localparam int CLASS_W       = 4;
    localparam int SLOT_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PTR_W         = (ORDER_LEN > 1) ? $clog2(ORDER_LEN) : 1;
    localparam int PASS_W        = $clog2(ORDER_LEN + 1);
    localparam int ORDER_W       = CLASS_ENTRIES * CLASS_W;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam logic [ORDER_W-1:0] CLASS_ORDER_RESET = 36'h221111213;

    // operation codes
    localparam logic [2:0] MODE_CREATE   = 3'd0;
    localparam logic [2:0] MODE_KILL     = 3'd1;
    localparam logic [2:0] MODE_SWITCH   = 3'd2;
    localparam logic [2:0] MODE_START    = 3'd3;
    localparam logic [2:0] MODE_KILL_CUR = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NO_TASK = 2'd2;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] priority_req;
        logic [2:0] task_id;
    } sched_in_t;

    typedef struct packed {
        logic [2:0] task_id_res;
        logic [1:0] status;
    } sched_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CREATE,
        ST_SW_LOAD,
        ST_SW_SCAN,
        ST_EXEC
    } state_t;

    // class at a given order position, entries past the register read as zero
    function automatic logic [CLASS_W-1:0] class_at(
        input logic [ORDER_W-1:0] order,
        input logic [PTR_W-1:0]   ptr
    );
        logic [CLASS_W-1:0] cls;
        cls = '0;
        for (int k = 0; k < CLASS_ENTRIES; k++) begin
            if (int'(ptr) == k) begin
                cls = order[k*CLASS_W +: CLASS_W];
            end
        end
        return cls;
    endfunction

    // pointer step with wrap at the end of the order
    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr >= PTR_W'(ORDER_LEN - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// File: src/class_order_task_scheduler.sv
// top level of the class-order task scheduler: slot table, sequencer and apb registers
//
//  port group  | role                      | handshake
//  ------------+---------------------------+-------------------------------
//  s_*         | command word in           | s_valid / s_ready
//  m_*         | result word out           | m_valid / m_ready
//  p*          | class order register, apb | psel & penable, pready tied high
//
//  create: one slot tested per cycle against the valid bits
//  switch: one slot per cycle through the pointer-advance / class compare unit
//  kill, kill-current, start and unknown codes: handled in the exec state
//  reset (aresetn low, sync) clears valid bits, current task, pointer and the result valid bit
//  a finished result waits in the output reg; the final step stalls while it is full and m_ready is low
`default_nettype none

module class_order_task_scheduler (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // command words
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire cots_pkg::sched_in_t           s_data,
    // result words
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output cots_pkg::sched_out_t               m_data,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cots_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cots_pkg::PDATA_W-1:0]  pwdata,
    output logic      [cots_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    import cots_pkg::*;

    // sequencer
    state_t state_reg, state_next;

    // captured command word
    sched_in_t in_reg, in_next;

    // slot table: valid bits cleared on reset, priorities in plain flops
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [CLASS_W-1:0]   prio_reg [NUM_SLOTS];
    logic                 prio_we;
    logic [SLOT_W-1:0]    prio_wr_idx;
    logic [CLASS_W-1:0]   prio_wr_data;

    // scheduler state
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [CLASS_W-1:0] now_reg, now_next;

    // scan counters
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [PASS_W-1:0] pass_reg, pass_next;

    // class order register
    logic [ORDER_W-1:0] order_reg;

    // result register
    logic       m_valid_reg, m_valid_next;
    sched_out_t m_data_reg, m_data_next;

    // single read port on the priority table: current task while loading now, else scan slot
    logic [SLOT_W-1:0]  rd_idx;
    logic [CLASS_W-1:0] prio_rd;

    // shared scan unit
    logic [PTR_W-1:0] ptr_adv;
    logic             scan_hit;
    logic             last_slot;
    logic             last_pass;
    logic             create_free;
    logic             create_done;
    logic             scan_done;
    logic             out_free;

    logic [SLOT_W-1:0] kill_idx;
    logic              kill_in_range;

    assign out_free = !m_valid_reg || m_ready;
    assign rd_idx   = (state_reg == ST_SW_LOAD) ? cur_reg : idx_reg;
    assign prio_rd  = prio_reg[rd_idx];

    // advance the pointer past the running class, then match the slot against it
    assign ptr_adv   = (class_at(order_reg, ptr_reg) == now_reg) ? ptr_step(ptr_reg) : ptr_reg;
    assign scan_hit  = valid_reg[idx_reg] && (prio_rd == class_at(order_reg, ptr_adv));
    assign last_slot = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign last_pass = (pass_reg == PASS_W'(ORDER_LEN));

    assign create_free = !valid_reg[idx_reg];
    assign create_done = create_free || last_slot;
    assign scan_done   = scan_hit || (last_slot && last_pass);

    assign kill_idx      = SLOT_W'(in_reg.task_id);
    assign kill_in_range = (int'(in_reg.task_id) < NUM_SLOTS);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    priority if (s_data.mode == MODE_CREATE) begin
                        state_next = ST_CREATE;
                    end else if (s_data.mode == MODE_SWITCH) begin
                        state_next = ST_SW_LOAD;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_CREATE: begin
                if (create_done && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SW_LOAD: begin
                state_next = ST_SW_SCAN;
            end
            ST_SW_SCAN: begin
                if (scan_done && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        in_next      = in_reg;
        valid_next   = valid_reg;
        prio_we      = 1'b0;
        prio_wr_idx  = idx_reg;
        prio_wr_data = in_reg.priority_req;
        cur_next     = cur_reg;
        ptr_next     = ptr_reg;
        now_next     = now_reg;
        idx_next     = idx_reg;
        pass_next    = pass_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next   = s_data;
                    idx_next  = '0;
                    pass_next = '0;
                end
            end
            ST_CREATE: begin
                if (create_done && out_free) begin
                    m_valid_next = 1'b1;
                    if (create_free) begin
                        valid_next[idx_reg]     = 1'b1;
                        prio_we                 = 1'b1;
                        m_data_next.task_id_res = 3'(idx_reg);
                        m_data_next.status      = STATUS_OK;
                    end else begin
                        m_data_next.task_id_res = '0;
                        m_data_next.status      = STATUS_FULL;
                    end
                end else if (!create_done) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SW_LOAD: begin
                now_next = prio_rd;
            end
            ST_SW_SCAN: begin
                if (!scan_done || out_free) begin
                    ptr_next = ptr_adv;
                    if (scan_hit) begin
                        cur_next                = idx_reg;
                        m_valid_next            = 1'b1;
                        m_data_next.task_id_res = 3'(idx_reg);
                        m_data_next.status      = STATUS_OK;
                    end else if (scan_done) begin
                        m_valid_next            = 1'b1;
                        m_data_next.task_id_res = 3'(cur_reg);
                        m_data_next.status      = STATUS_NO_TASK;
                    end else if (last_slot) begin
                        idx_next  = '0;
                        pass_next = pass_reg + 1'b1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_data_next.status = STATUS_OK;
                    unique case (in_reg.mode)
                        MODE_KILL: begin
                            if (kill_in_range) begin
                                valid_next[kill_idx] = 1'b0;
                            end
                            m_data_next.task_id_res = in_reg.task_id;
                        end
                        MODE_START: begin
                            cur_next                = '0;
                            ptr_next                = '0;
                            m_data_next.task_id_res = '0;
                        end
                        MODE_KILL_CUR: begin
                            valid_next[cur_reg]     = 1'b0;
                            m_data_next.task_id_res = 3'(cur_reg);
                        end
                        default: begin
                            m_data_next.task_id_res = 3'(cur_reg);
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            cur_reg     <= '0;
            ptr_reg     <= '0;
            idx_reg     <= '0;
            pass_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            cur_reg     <= cur_next;
            ptr_reg     <= ptr_next;
            idx_reg     <= idx_next;
            pass_reg    <= pass_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        now_reg    <= now_next;
        m_data_reg <= m_data_next;
    end

    // priority table, zero after reset to match the stored-priority read of a fresh slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                prio_reg[i] <= '0;
            end
        end else if (prio_we) begin
            prio_reg[prio_wr_idx] <= prio_wr_data;
        end
    end

    // class order register, 36 bits on the 64-bit data bus, selected while paddr[3] is low
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= CLASS_ORDER_RESET;
        end else if (psel && penable && pwrite && !paddr[PADDR_W-1]) begin
            order_reg <= pwdata[ORDER_W-1:0];
        end
    end

    assign prdata  = paddr[PADDR_W-1] ? '0 : PDATA_W'(order_reg);
    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // an accepted command word always puts the sequencer to work
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted word left the sequencer idle");

    // a result appears only at the end of a busy step
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) != ST_IDLE))
        else $error("result raised without work");

    // a successful create marks its slot taken
    a_create_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CREATE && create_free && out_free)
            |=> valid_reg[$past(idx_reg)])
        else $error("created slot not marked valid");

    // the order pointer never leaves the order
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SW_SCAN) |-> (int'(ptr_adv) < ORDER_LEN))
        else $error("order pointer out of range");

endmodule

`default_nettype wire
